FILE: rtl/core/assert_macros.svh
// Assertion helper macros for the convolution core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/core/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants of the multichannel convolution core.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int MAX_IMAGE_D  = 64;
    localparam int MAX_KERNEL_D = 7;
    localparam int MAX_IN_CH_D  = 16;
    localparam int MAX_OUT_CH_D = 16;
    localparam int DATA_WIDTH_D = 16;
    localparam int SUM_W        = 48;
    localparam int CFG_W        = 7;

    localparam logic [1:0] REG_IMAGE  = 2'd0;
    localparam logic [1:0] REG_KERNEL = 2'd1;
    localparam logic [1:0] REG_IN_CH  = 2'd2;
    localparam logic [1:0] REG_OUT_CH = 2'd3;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] data_value;
        logic [3:0]  weight_out_channel;
        logic [3:0]  weight_in_channel;
        logic [2:0]  weight_row;
        logic [2:0]  weight_col;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  result_channel;
        logic [5:0]  result_row;
        logic [5:0]  result_col;
        logic [47:0] conv_sum;
        logic        last_of_run;
    } out_word_t;

    // MAC control from sequencer to datapath
    typedef struct packed {
        logic clear;
        logic acc;
    } mac_ctl_t;

endpackage

FILE: rtl/core/multichannel_conv2d_valid.sv
// ----------------------------------------------------------------------------
// multichannel_conv2d_valid
// Multi-channel 2D valid convolution, stride 1, with one shared MAC unit.
// ----------------------------------------------------------------------------
// Input words (valid/stall) carry either a kernel weight (func 0) or one pixel
// sample (func 1); pixels come in raster order, channel innermost. A weight
// word, or a pixel word that closes no window, passes through S_WIN back to
// S_IDLE. When the last channel of a pixel closes a KxK window, then for each
// output channel the MAC walks in_channels*K*K taps (one weight read and one
// row-store read per cycle) and S_DRAIN lets the product pipeline empty;
// in_stall stays high until S_IDLE is reached again. Results leave through
// an output register on the valid/stall channel, one per output channel in
// order, last_of_run on the final one. A stalled result holds the sequencer.
// Config writes (index 0..3) restart the pixel stream at row 0, column 0.
// Reset clears control and the config registers to 28, 5, 3, 8; the weight
// and row stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module multichannel_conv2d_valid #(
    parameter int MAX_IMAGE  = mcc_pkg::MAX_IMAGE_D,
    parameter int MAX_KERNEL = mcc_pkg::MAX_KERNEL_D,
    parameter int MAX_IN_CH  = mcc_pkg::MAX_IN_CH_D,
    parameter int MAX_OUT_CH = mcc_pkg::MAX_OUT_CH_D,
    parameter int DATA_WIDTH = mcc_pkg::DATA_WIDTH_D
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  mcc_pkg::in_word_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output mcc_pkg::out_word_t        out_data,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [mcc_pkg::CFG_W-1:0] cfg_data
);
    import mcc_pkg::*;

    localparam int KK     = MAX_KERNEL * MAX_KERNEL;
    localparam int W_DEP  = MAX_OUT_CH * MAX_IN_CH * KK;
    localparam int R_DEP  = MAX_KERNEL * MAX_IMAGE * MAX_IN_CH;
    localparam int WA_W   = $clog2(W_DEP + 1);
    localparam int RA_W   = $clog2(R_DEP + 1);
    localparam int IMG_W  = $clog2(MAX_IMAGE + 1);
    localparam int KR_W   = $clog2(MAX_KERNEL + 1);
    localparam int IC_W   = $clog2(MAX_IN_CH + 1);
    localparam int OC_W   = $clog2(MAX_OUT_CH + 1);

    typedef enum logic [2:0] {S_IDLE, S_WIN, S_MAC, S_DRAIN, S_OUT} state_t;

    // memories
    logic signed [DATA_WIDTH-1:0] wmem [W_DEP];
    logic signed [DATA_WIDTH-1:0] rmem [R_DEP];
    logic signed [DATA_WIDTH-1:0] wrd_reg, rrd_reg;

    // config
    logic [6:0] img_cfg_reg;
    logic [2:0] ker_cfg_reg;
    logic [4:0] ic_cfg_reg, oc_cfg_reg;
    logic [IMG_W-1:0] n_c;
    logic [KR_W-1:0]  k_c;
    logic [IC_W-1:0]  ci_c;
    logic [OC_W-1:0]  co_c;

    // position and sequencer
    state_t           state_reg;
    logic [IMG_W-1:0] prow_reg, pcol_reg, r0_reg, c0_reg;
    logic [IC_W-1:0]  pch_reg;
    logic [OC_W-1:0]  oc_reg;
    logic [IC_W-1:0]  ic_reg;
    logic [KR_W-1:0]  i_reg, j_reg;
    logic [1:0]       drain_reg;
    logic             done_reg;
    mac_ctl_t         ctl;
    logic signed [47:0] acc;

    // clamp registers into range
    always_comb
    begin
        n_c  = (img_cfg_reg == 0) ? IMG_W'(1) :
               (32'(img_cfg_reg) > MAX_IMAGE) ? IMG_W'(MAX_IMAGE) : IMG_W'(img_cfg_reg);
        k_c  = (ker_cfg_reg == 0) ? KR_W'(1) :
               (32'(ker_cfg_reg) > MAX_KERNEL) ? KR_W'(MAX_KERNEL) : KR_W'(ker_cfg_reg);
        ci_c = (ic_cfg_reg == 0) ? IC_W'(1) :
               (32'(ic_cfg_reg) > MAX_IN_CH) ? IC_W'(MAX_IN_CH) : IC_W'(ic_cfg_reg);
        co_c = (oc_cfg_reg == 0) ? OC_W'(1) :
               (32'(oc_cfg_reg) > MAX_OUT_CH) ? OC_W'(MAX_OUT_CH) : OC_W'(oc_cfg_reg);
    end

    // current pixel position, wrapped when outside the configuration
    logic [IMG_W-1:0] row_c, col_c;
    logic [IC_W-1:0]  ch_c;
    logic             oob;
    assign oob   = (prow_reg >= n_c) || (pcol_reg >= n_c) || (pch_reg >= ci_c);
    assign row_c = oob ? '0 : prow_reg;
    assign col_c = oob ? '0 : pcol_reg;
    assign ch_c  = oob ? '0 : pch_reg;

    // address arithmetic (small constant multiplies)
    logic [WA_W-1:0] wa_in, wa_mac;
    logic [RA_W-1:0] ra_in, ra_mac;
    logic            w_ok;
    logic [IMG_W:0]  rr_mac, cc_mac;
    assign w_ok  = (32'(in_data.weight_out_channel) < MAX_OUT_CH) &&
                   (32'(in_data.weight_in_channel) < MAX_IN_CH) &&
                   (32'(in_data.weight_row) < MAX_KERNEL) &&
                   (32'(in_data.weight_col) < MAX_KERNEL);
    assign wa_in = WA_W'(((32'(in_data.weight_out_channel) * MAX_IN_CH +
                   32'(in_data.weight_in_channel)) * MAX_KERNEL +
                   32'(in_data.weight_row)) * MAX_KERNEL + 32'(in_data.weight_col));
    assign ra_in = RA_W'(((32'(row_c) % MAX_KERNEL) * MAX_IMAGE + 32'(col_c)) * MAX_IN_CH
                   + 32'(ch_c));
    assign wa_mac = WA_W'(((32'(oc_reg) * MAX_IN_CH + 32'(ic_reg)) * MAX_KERNEL +
                    32'(i_reg)) * MAX_KERNEL + 32'(j_reg));
    assign rr_mac = (IMG_W+1)'(r0_reg) + (IMG_W+1)'(i_reg);
    assign cc_mac = (IMG_W+1)'(c0_reg) + (IMG_W+1)'(j_reg);
    assign ra_mac = RA_W'(((32'(rr_mac) % MAX_KERNEL) * MAX_IMAGE + 32'(cc_mac)) * MAX_IN_CH
                    + 32'(ic_reg));

    logic acc_in;
    assign in_stall = (state_reg != S_IDLE);
    assign acc_in   = in_valid && !in_stall;

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (acc_in && in_data.func == FUNC_WEIGHT && w_ok)
            wmem[wa_in] <= signed'(DATA_WIDTH'(in_data.data_value));
        if (acc_in && in_data.func == FUNC_PIXEL)
            rmem[ra_in] <= signed'(DATA_WIDTH'(in_data.data_value));
        wrd_reg <= wmem[wa_mac];
        rrd_reg <= rmem[ra_mac];
    end

    // read issued in S_MAC arrives next cycle; product is registered in the cycle after that
    logic rd_vld_reg, rd_first_reg;
    assign ctl.acc   = rd_vld_reg;
    assign ctl.clear = rd_first_reg;

    mcc_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .a(wrd_reg), .b(rrd_reg), .acc(acc)
    );

    logic last_tap;
    assign last_tap = (j_reg + 1'b1 == k_c) && (i_reg + 1'b1 == k_c) &&
                      (ic_reg + 1'b1 == ci_c);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            img_cfg_reg  <= 7'd28;
            ker_cfg_reg  <= 3'd5;
            ic_cfg_reg   <= 5'd3;
            oc_cfg_reg   <= 5'd8;
            prow_reg     <= '0;
            pcol_reg     <= '0;
            pch_reg      <= '0;
            r0_reg       <= '0;
            c0_reg       <= '0;
            oc_reg       <= '0;
            ic_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            drain_reg    <= '0;
            done_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            out_valid    <= 1'b0;
            out_data     <= '0;
        end
        else
        begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE:  img_cfg_reg <= cfg_data;
                    REG_KERNEL: ker_cfg_reg <= cfg_data[2:0];
                    REG_IN_CH:  ic_cfg_reg  <= cfg_data[4:0];
                    REG_OUT_CH: oc_cfg_reg  <= cfg_data[4:0];
                    default:    ;
                endcase
                prow_reg <= '0;
                pcol_reg <= '0;
                pch_reg  <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in)
                    begin
                        state_reg <= S_WIN;
                        if (in_data.func == FUNC_PIXEL)
                        begin
                            if (ch_c + 1'b1 < ci_c)
                                pch_reg <= ch_c + 1'b1;
                            else
                            begin
                                pch_reg <= '0;
                                if (col_c + 1'b1 < n_c)
                                    pcol_reg <= col_c + 1'b1;
                                else
                                begin
                                    pcol_reg <= '0;
                                    prow_reg <= (row_c + 1'b1 < n_c) ? row_c + 1'b1 : '0;
                                end
                            end
                            if (ch_c + 1'b1 == ci_c && (IMG_W+1)'(row_c) + 1'b1 >=
                                (IMG_W+1)'(k_c) && (IMG_W+1)'(col_c) + 1'b1 >=
                                (IMG_W+1)'(k_c))
                            begin
                                state_reg <= S_MAC;
                                r0_reg    <= IMG_W'((IMG_W+1)'(row_c) + 1'b1 - (IMG_W+1)'(k_c));
                                c0_reg    <= IMG_W'((IMG_W+1)'(col_c) + 1'b1 - (IMG_W+1)'(k_c));
                                oc_reg    <= '0;
                                ic_reg    <= '0;
                                i_reg     <= '0;
                                j_reg     <= '0;
                                rd_first_reg <= 1'b0;
                            end
                        end
                    end
                end
                S_WIN:
                    state_reg <= S_IDLE;
                S_MAC:
                begin
                    rd_vld_reg   <= 1'b1;
                    rd_first_reg <= (ic_reg == 0) && (i_reg == 0) && (j_reg == 0);
                    if (last_tap)
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= '0;
                    end
                    else if (j_reg + 1'b1 < k_c)
                        j_reg <= j_reg + 1'b1;
                    else
                    begin
                        j_reg <= '0;
                        if (i_reg + 1'b1 < k_c)
                            i_reg <= i_reg + 1'b1;
                        else
                        begin
                            i_reg  <= '0;
                            ic_reg <= ic_reg + 1'b1;
                        end
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 2'd2 && (!out_valid || !out_stall))
                    begin
                        out_valid <= 1'b1;
                        out_data.result_channel <= 4'(oc_reg);
                        out_data.result_row     <= 6'(r0_reg);
                        out_data.result_col     <= 6'(c0_reg);
                        out_data.conv_sum       <= acc;
                        out_data.last_of_run    <= (oc_reg + 1'b1 == co_c);
                        state_reg <= S_OUT;
                    end
                    else if (drain_reg == 2'd2)
                        drain_reg <= 2'd2;
                end
                S_OUT:
                begin
                    if (oc_reg + 1'b1 == co_c)
                        state_reg <= S_IDLE;
                    else
                    begin
                        oc_reg    <= oc_reg + 1'b1;
                        ic_reg    <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_MAC;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            done_reg <= (state_reg == S_OUT);
            if (out_valid && !out_stall && !(state_reg == S_DRAIN && drain_reg == 2'd2))
                out_valid <= 1'b0;
        end
    end

    // checks
    `ASSERT_NEVER(a_no_input_busy, clk, rst_n, acc_in && state_reg != S_IDLE, "input taken while busy")
    `ASSERT_IMPL(a_out_after_drain, clk, rst_n, $rose(out_valid) |-> $past(state_reg == S_DRAIN), "result not from drain")
    `ASSERT_IMPL(a_done_follows, clk, rst_n, done_reg |-> out_valid || $past(out_valid), "done without result")

endmodule

FILE: rtl/core/mcc_mac.sv
// ----------------------------------------------------------------------------
// mcc_mac
// Shared multiply-accumulate unit: registered product, then 48-bit accumulate.
// ----------------------------------------------------------------------------
module mcc_mac #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mcc_pkg::mac_ctl_t            ctl,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [47:0]           acc
);
    import mcc_pkg::*;

    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic                           prod_vld_reg;
    logic                           clr_reg;
    logic signed [SUM_W-1:0]        prod_ext;

    always_comb
    begin
        if (2*DATA_WIDTH >= SUM_W)
            prod_ext = SUM_W'(prod_reg);
        else
            prod_ext = SUM_W'(signed'(prod_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            clr_reg      <= 1'b0;
            acc          <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.acc;
            clr_reg      <= ctl.clear;
            if (clr_reg)
                acc <= prod_vld_reg ? prod_ext : '0;
            else if (prod_vld_reg)
                acc <= acc + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel 2D valid convolution core. A short
// directed table covers extremes, saturated registers and ignored weights, and
// then random pixel streams run over several kernel/image/channel settings.
// Every result word is compared against a hand-written value or a local predictor.
// ----------------------------------------------------------------------------
module testbench;
    import mcc_pkg::*;

    localparam int WSTORE_D = MAX_OUT_CH_D * MAX_IN_CH_D * MAX_KERNEL_D * MAX_KERNEL_D;
    localparam int RSTORE_D = MAX_KERNEL_D * MAX_IMAGE_D * MAX_IN_CH_D;
    localparam int LIMIT    = 3000000;
    localparam int SETTLE   = 40;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] cfg_idx;
        logic [6:0] cfg_val;
        in_word_t   word;
        bit         typed;
        int         nres;
        out_word_t  res;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;
    logic      cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [15:0] kern_mem [WSTORE_D];
    logic signed [15:0] line_mem [RSTORE_D];
    bit                 kern_written [WSTORE_D];
    int unsigned        pos_row, pos_col, pos_ch;
    logic [6:0]         reg_image, reg_kernel, reg_inch, reg_outch;

    out_word_t sums_pending[$];
    out_word_t fresh_sums[$];
    int        errors = 0;
    bit        in_burst = 1'b0;
    bit        out_burst = 1'b0;

    multichannel_conv2d_valid dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned sat(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int kidx(int unsigned oc, int unsigned ic, int unsigned r,
                                int unsigned c);
        return ((oc * MAX_IN_CH_D + ic) * MAX_KERNEL_D + r) * MAX_KERNEL_D + c;
    endfunction

    function automatic int lidx(int unsigned row, int unsigned col, int unsigned ch);
        return ((row % MAX_KERNEL_D) * MAX_IMAGE_D + col) * MAX_IN_CH_D + ch;
    endfunction

    // Convolution predictor: updates state, leaves results in fresh_sums
    task automatic predict_word(input in_word_t w);
        int unsigned n, k, ci, co, row, col, ch, r0, c0;
        logic signed [47:0] acc;
        out_word_t o;
        n  = sat(reg_image, MAX_IMAGE_D);
        k  = sat(reg_kernel, MAX_KERNEL_D);
        ci = sat(reg_inch, MAX_IN_CH_D);
        co = sat(reg_outch, MAX_OUT_CH_D);
        fresh_sums.delete();
        if (w.func == FUNC_WEIGHT)
        begin
            // row or column 7 lies outside the store and is dropped
            if (w.weight_row < MAX_KERNEL_D && w.weight_col < MAX_KERNEL_D)
            begin
                kern_mem[kidx(w.weight_out_channel, w.weight_in_channel,
                              w.weight_row, w.weight_col)] = w.data_value;
                kern_written[kidx(w.weight_out_channel, w.weight_in_channel,
                                  w.weight_row, w.weight_col)] = 1'b1;
            end
            return;
        end
        if (pos_row >= n || pos_col >= n || pos_ch >= ci)
        begin
            pos_row = 0; pos_col = 0; pos_ch = 0;
        end
        row = pos_row; col = pos_col; ch = pos_ch;
        line_mem[lidx(row, col, ch)] = w.data_value;
        if (ch + 1 < ci)
            pos_ch = ch + 1;
        else
        begin
            pos_ch = 0;
            if (col + 1 < n)
                pos_col = col + 1;
            else
            begin
                pos_col = 0;
                pos_row = (row + 1 < n) ? row + 1 : 0;
            end
        end
        if (ch + 1 == ci && row + 1 >= k && col + 1 >= k)
        begin
            r0 = row + 1 - k;
            c0 = col + 1 - k;
            for (int unsigned oc = 0; oc < co; oc++)
            begin
                acc = '0;
                for (int unsigned ic = 0; ic < ci; ic++)
                    for (int unsigned i = 0; i < k; i++)
                        for (int unsigned j = 0; j < k; j++)
                            acc = acc + kern_mem[kidx(oc, ic, i, j)] *
                                        line_mem[lidx(r0 + i, c0 + j, ic)];
                o.result_channel = oc[3:0];
                o.result_row     = r0[5:0];
                o.result_col     = c0[5:0];
                o.conv_sum       = acc;
                o.last_of_run    = (oc + 1 == co);
                fresh_sums.push_back(o);
            end
        end
    endtask

    // Send one input word; predict at the accepting edge
    task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                             input int nres = 0, input out_word_t res = '0);
        int gap;
        if (($urandom_range(0, 15)) == 0)
            in_burst = ~in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(w);
        if (typed)
        begin
            if (nres > 0)
                sums_pending.push_back(res);
        end
        else
            foreach (fresh_sums[i])
                sums_pending.push_back(fresh_sums[i]);
    endtask

    // Block is idle: all results in, then a margin for a trailing weight word
    task automatic wait_idle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (sums_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE:  reg_image  = val;
            REG_KERNEL: reg_kernel = {4'd0, val[2:0]};
            REG_IN_CH:  reg_inch   = {2'd0, val[4:0]};
            REG_OUT_CH: reg_outch  = {2'd0, val[4:0]};
        endcase
        pos_row = 0; pos_col = 0; pos_ch = 0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_word_t weight_word(int unsigned oc, int unsigned ic,
                                             int unsigned r, int unsigned c,
                                             logic [15:0] v);
        in_word_t w;
        w.func = FUNC_WEIGHT;
        w.data_value = v;
        w.weight_out_channel = oc[3:0];
        w.weight_in_channel = ic[3:0];
        w.weight_row = r[2:0];
        w.weight_col = c[2:0];
        return w;
    endfunction

    function automatic in_word_t pixel_word(logic [15:0] v);
        in_word_t w;
        w = $urandom();          // weight fields are don't-care on pixels
        w.func = FUNC_PIXEL;
        w.data_value = v;
        return w;
    endfunction

    // One random phase: registers, missing weights, then the pixel stream
    task automatic run_phase(input logic [6:0] img, input logic [6:0] ker,
                             input logic [6:0] ci_raw, input logic [6:0] co_raw,
                             input int nitems);
        int unsigned k, ci, co;
        wait_idle();
        write_reg(REG_IMAGE, img);
        write_reg(REG_KERNEL, ker);
        write_reg(REG_IN_CH, ci_raw);
        write_reg(REG_OUT_CH, co_raw);
        k  = sat(reg_kernel, MAX_KERNEL_D);
        ci = sat(reg_inch, MAX_IN_CH_D);
        co = sat(reg_outch, MAX_OUT_CH_D);
        in_burst  = $urandom_range(0, 1);
        out_burst = $urandom_range(0, 1);
        for (int unsigned oc = 0; oc < co; oc++)
            for (int unsigned ic = 0; ic < ci; ic++)
                for (int unsigned r = 0; r < k; r++)
                    for (int unsigned c = 0; c < k; c++)
                        if (!kern_written[kidx(oc, ic, r, c)])
                            send_word(weight_word(oc, ic, r, c, rand_sample()));
        // mostly pixels, a few weight rewrites anywhere (row/col 7 included)
        repeat (nitems)
        begin
            if ($urandom_range(0, 6) == 0)
                send_word(weight_word($urandom_range(0, 15), $urandom_range(0, 15),
                                      $urandom_range(0, 7), $urandom_range(0, 7),
                                      rand_sample()));
            else
                send_word(pixel_word(rand_sample()));
        end
    endtask

    // Result side: random stall after each accepted word, compare with oldest
    initial
    begin
        out_word_t exp_w;
        int        hold;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (sums_pending.size() == 0)
                begin
                    $error("result word with none expected: %p", out_data);
                    errors++;
                end
                else
                begin
                    exp_w = sums_pending.pop_front();
                    if (out_data.result_channel !== exp_w.result_channel)
                    begin
                        $error("result_channel expected %0d actual %0d",
                               exp_w.result_channel, out_data.result_channel);
                        errors++;
                    end
                    if (out_data.result_row !== exp_w.result_row)
                    begin
                        $error("result_row expected %0d actual %0d",
                               exp_w.result_row, out_data.result_row);
                        errors++;
                    end
                    if (out_data.result_col !== exp_w.result_col)
                    begin
                        $error("result_col expected %0d actual %0d",
                               exp_w.result_col, out_data.result_col);
                        errors++;
                    end
                    if (out_data.conv_sum !== exp_w.conv_sum)
                    begin
                        $error("conv_sum expected %0d actual %0d",
                               $signed(exp_w.conv_sum), $signed(out_data.conv_sum));
                        errors++;
                    end
                    if (out_data.last_of_run !== exp_w.last_of_run)
                    begin
                        $error("last_of_run expected %0d actual %0d",
                               exp_w.last_of_run, out_data.last_of_run);
                        errors++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    out_burst = ~out_burst;
                hold = out_burst ? 0 : $urandom_range(0, 13);
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Directed table, then random phases
    initial
    begin
        dir_row_t  dir_rows[$];
        dir_row_t  dr;
        out_word_t one;

        foreach (kern_mem[i]) kern_mem[i] = '0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (kern_written[i]) kern_written[i] = 1'b0;
        pos_row = 0; pos_col = 0; pos_ch = 0;
        reg_image = 7'd28; reg_kernel = 7'd5; reg_inch = 7'd3; reg_outch = 7'd8;

        one.result_channel = '0;
        one.result_row = '0;
        one.result_col = '0;
        one.last_of_run = 1'b1;

        // after reset: weight past the store, pixels that close no window
        dr = '{ROW_WORD, REG_IMAGE, 7'd0, weight_word(15, 15, 7, 6, 16'h7fff), 1, 0, '0};
        dir_rows.push_back(dr);
        dr.word = pixel_word(16'h7fff);  dir_rows.push_back(dr);
        dr.word = pixel_word(16'h8000);  dir_rows.push_back(dr);
        // all registers at 1: one product per pixel
        dr.kind = ROW_CFG;
        dr.cfg_idx = REG_IMAGE;  dr.cfg_val = 7'd1; dir_rows.push_back(dr);
        dr.cfg_idx = REG_KERNEL; dir_rows.push_back(dr);
        dr.cfg_idx = REG_IN_CH;  dir_rows.push_back(dr);
        dr.cfg_idx = REG_OUT_CH; dir_rows.push_back(dr);
        dr.kind = ROW_WORD;
        dr.word = weight_word(0, 0, 0, 0, 16'h8000); dir_rows.push_back(dr);
        dr.word = weight_word(0, 0, 0, 7, 16'h0005); dir_rows.push_back(dr);
        dr.nres = 1;
        dr.word = pixel_word(16'h8000); dr.res = one;
        dr.res.conv_sum = 48'sd1073741824;  dir_rows.push_back(dr);
        dr.word = pixel_word(16'h7fff);
        dr.res.conv_sum = -48'sd1073709056; dir_rows.push_back(dr);
        dr.nres = 0;
        dr.word = weight_word(0, 0, 0, 0, 16'h7fff); dir_rows.push_back(dr);
        dr.nres = 1;
        dr.word = pixel_word(16'h7fff);
        dr.res.conv_sum = 48'sd1073676289;  dir_rows.push_back(dr);
        dr.word = pixel_word(16'h0000);
        dr.res.conv_sum = 48'sd0;           dir_rows.push_back(dr);
        // kernel larger than image: nothing comes out
        dr.kind = ROW_CFG; dr.cfg_idx = REG_KERNEL; dr.cfg_val = 7'd2; dir_rows.push_back(dr);
        dr.kind = ROW_WORD; dr.nres = 0;
        dr.word = pixel_word(16'h0001);     dir_rows.push_back(dr);
        // zero in every register saturates to 1
        dr.kind = ROW_CFG; dr.cfg_val = 7'd0;
        dr.cfg_idx = REG_KERNEL; dir_rows.push_back(dr);
        dr.cfg_idx = REG_IN_CH;  dir_rows.push_back(dr);
        dr.cfg_idx = REG_OUT_CH; dir_rows.push_back(dr);
        dr.cfg_idx = REG_IMAGE;  dir_rows.push_back(dr);
        dr.kind = ROW_WORD; dr.nres = 1;
        dr.word = pixel_word(16'hffff);
        dr.res.conv_sum = -48'sd32767;      dir_rows.push_back(dr);
        // one unchecked-by-hand row through the predictor
        dr.typed = 1'b0;
        dr.word = pixel_word(16'h1234);     dir_rows.push_back(dr);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end
            else
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].nres,
                          dir_rows[i].res);
        end

        run_phase(7'd5,   7'd3, 7'd2,  7'd3,  90);
        run_phase(7'd1,   7'd1, 7'd1,  7'd1,  20);
        run_phase(7'd4,   7'd7, 7'd2,  7'd2,  30);
        run_phase(7'd64,  7'd1, 7'd1,  7'd2,  70);
        run_phase(7'd7,   7'd7, 7'd1,  7'd16, 60);
        run_phase(7'd100, 7'd1, 7'd31, 7'd31, 60);
        run_phase(7'd3,   7'd2, 7'd16, 7'd4,  100);
        run_phase(7'd6,   7'd4, 7'd3,  7'd5,  70);

        wait_idle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
